FILE: sv/ptw_pkg.sv
// Shared types and constants for the page table walker.
package ptw_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned VA_W      = 48;
  localparam int unsigned ROOT_W    = 40;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned PA_W      = 52;
  localparam int unsigned BLEN_W    = 10;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned TOP_DEPTH = 512;

  // Request type codes on the input channel.
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_READ_DATA = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // Page size codes.
  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  // Burst lengths in 8-byte words.
  localparam logic [BLEN_W-1:0] BURST_TABLE = 10'd512;
  localparam logic [BLEN_W-1:0] BURST_ONE   = 10'd1;

  // Input beat.
  typedef struct packed {
    logic              req_type;
    logic [VA_W-1:0]   virt_addr;
    logic [ROOT_W-1:0] root_frame;
    logic [DATA_W-1:0] read_data;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]        out_kind;
    logic [PA_W-1:0]   mem_addr;
    logic [BLEN_W-1:0] burst_len;
    logic [PA_W-1:0]   phys_addr;
    logic [1:0]        page_kind;
  } out_item_t;

  // Classified command passed from the front end to the walker.
  typedef enum logic {
    CMD_TRANSLATE,
    CMD_DATA
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [VA_W-1:0]   va;
    logic [ROOT_W-1:0] root;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

FILE: sv/ptw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ptw_front.sv
// Front end: accepts input beats, classifies them and queues them for the walker.
module ptw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptw_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output ptw_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  ptw_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;
  logic          pop;
  ptw_pkg::cmd_t cmd_new;

  // Decode the beat into a command.
  always_comb begin
    cmd_new.kind = (in_item_i.req_type == ptw_pkg::REQ_READ_DATA) ?
                   ptw_pkg::CMD_DATA : ptw_pkg::CMD_TRANSLATE;
    cmd_new.va   = in_item_i.virt_addr;
    cmd_new.root = in_item_i.root_frame;
    cmd_new.data = in_item_i.read_data;
  end

  // The queue stalls the input only when both slots are taken.
  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: sv/ptw_back.sv
// Back end: walks the page tables, owns the top-level cache and the result register.
module ptw_back #(
  parameter int unsigned PHYS_BITS = 52
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ptw_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptw_pkg::out_item_t out_item_o
);

  localparam int unsigned PaW   = ptw_pkg::PA_W;
  localparam int unsigned IdxW  = ptw_pkg::IDX_W;
  localparam logic [PaW-1:0] PhysMask = (52'(1) << PHYS_BITS) - 52'(1);
  localparam logic [PaW-1:0] Frame4k  = ~52'hFFF;
  localparam logic [PaW-1:0] Frame2m  = ~52'h1FFFFF;
  localparam logic [PaW-1:0] Frame1g  = ~52'h3FFFFFFF;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ptw_pkg::TOP_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_FILL_CHECK,
    ST_L3,
    ST_L2,
    ST_L1
  } state_e;

  state_e                      state_q, state_d;
  logic [ptw_pkg::VA_W-1:0]    va_q, va_d;
  logic [ptw_pkg::ROOT_W-1:0]  root_q, root_d;
  logic [IdxW-1:0]             fill_cnt_q, fill_cnt_d;
  logic                        cache_valid_q, cache_valid_d;
  logic [ptw_pkg::DATA_W-1:0]  byp_q, byp_d;
  logic                        use_byp_q, use_byp_d;
  logic                        out_valid_q;
  ptw_pkg::out_item_t          out_q;

  logic                        out_free;
  logic                        is_data;
  logic                        emit;
  ptw_pkg::out_item_t          emit_item;
  logic                        ram_we;
  logic                        ram_re;
  logic [IdxW-1:0]             ram_raddr;
  logic [ptw_pkg::DATA_W-1:0]  ram_rdata;
  logic [ptw_pkg::DATA_W-1:0]  top_e;

  // Build one result beat; all addresses are clipped to the physical width.
  function automatic ptw_pkg::out_item_t mk_out(logic [1:0] kind, logic [PaW-1:0] maddr,
                                                logic [ptw_pkg::BLEN_W-1:0] blen,
                                                logic [PaW-1:0] paddr, logic [1:0] pkind);
    ptw_pkg::out_item_t o;
    o.out_kind  = kind;
    o.mem_addr  = maddr & PhysMask;
    o.burst_len = blen;
    o.phys_addr = paddr & PhysMask;
    o.page_kind = pkind;
    return o;
  endfunction

  // Single-word read of the next-level entry selected by a 9-bit index.
  function automatic ptw_pkg::out_item_t read_item(logic [ptw_pkg::DATA_W-1:0] entry,
                                                   logic [IdxW-1:0] idx);
    logic [PaW-1:0] addr;
    addr = (entry[PaW-1:0] & PhysMask & Frame4k) | {40'b0, idx, 3'b000};
    return mk_out(ptw_pkg::KIND_READ, addr, ptw_pkg::BURST_ONE, '0, 2'd0);
  endfunction

  function automatic ptw_pkg::out_item_t fault_item();
    return mk_out(ptw_pkg::KIND_FAULT, '0, '0, '0, 2'd0);
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_data  = (cmd_i.kind == ptw_pkg::CMD_DATA);

  // Translate beats that arrive mid-walk and data beats that arrive idle are
  // dropped; a beat that yields a result waits for room in the result register.
  always_comb begin
    case (state_q)
      ST_IDLE:       cmd_pop_o = cmd_valid_i;
      ST_FILL:       cmd_pop_o = cmd_valid_i;
      ST_L3, ST_L2, ST_L1: cmd_pop_o = cmd_valid_i && (!is_data || out_free);
      default:       cmd_pop_o = 1'b0;
    endcase
  end

  // Cache ports: refill words are written in order, lookups read at the top index.
  assign ram_we    = cmd_pop_o && is_data && (state_q == ST_FILL);
  assign ram_re    = (cmd_pop_o && !is_data && (state_q == ST_IDLE)) ||
                     (ram_we && (fill_cnt_q == LastIdx));
  assign ram_raddr = (state_q == ST_IDLE) ? cmd_i.va[47:39] : va_q[47:39];

  ptw_ram #(
    .WIDTH (ptw_pkg::DATA_W),
    .DEPTH (ptw_pkg::TOP_DEPTH)
  ) u_top_cache (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_cnt_q),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Until the first refill completes the cache reads as all zero.
  always_comb begin
    if (use_byp_q) begin
      top_e = byp_q;
    end else if (cache_valid_q) begin
      top_e = ram_rdata;
    end else begin
      top_e = '0;
    end
  end

  // Walk sequencing.
  always_comb begin
    state_d       = state_q;
    va_d          = va_q;
    root_d        = root_q;
    fill_cnt_d    = fill_cnt_q;
    cache_valid_d = cache_valid_q;
    byp_d         = byp_q;
    use_byp_d     = use_byp_q;
    emit          = 1'b0;
    emit_item     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && !is_data) begin
          va_d      = cmd_i.va;
          root_d    = cmd_i.root;
          use_byp_d = 1'b0;
          state_d   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          emit = 1'b1;
          if (top_e[0]) begin
            emit_item = read_item(top_e, va_q[38:30]);
            state_d   = ST_L3;
          end else begin
            emit_item  = mk_out(ptw_pkg::KIND_READ, {root_q, 12'b0}, ptw_pkg::BURST_TABLE,
                                '0, 2'd0);
            fill_cnt_d = '0;
            state_d    = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (cmd_pop_o && is_data) begin
          fill_cnt_d = fill_cnt_q + IdxW'(1);
          if (fill_cnt_q == LastIdx) begin
            // The last word may be the one the lookup needs: keep it aside.
            cache_valid_d = 1'b1;
            byp_d         = cmd_i.data;
            use_byp_d     = (va_q[47:39] == LastIdx);
            state_d       = ST_FILL_CHECK;
          end
        end
      end
      ST_FILL_CHECK: begin
        if (out_free) begin
          emit = 1'b1;
          if (top_e == '0) begin
            emit_item = fault_item();
            state_d   = ST_IDLE;
          end else begin
            emit_item = read_item(top_e, va_q[38:30]);
            state_d   = ST_L3;
          end
        end
      end
      ST_L3: begin
        if (cmd_pop_o && is_data) begin
          emit = 1'b1;
          if (cmd_i.data == '0) begin
            emit_item = fault_item();
            state_d   = ST_IDLE;
          end else if (cmd_i.data[7]) begin
            emit_item = mk_out(ptw_pkg::KIND_DONE, '0, '0,
                               (cmd_i.data[PaW-1:0] & PhysMask & Frame1g) |
                               {22'b0, va_q[29:0]}, ptw_pkg::PAGE_1G);
            state_d   = ST_IDLE;
          end else begin
            emit_item = read_item(cmd_i.data, va_q[29:21]);
            state_d   = ST_L2;
          end
        end
      end
      ST_L2: begin
        if (cmd_pop_o && is_data) begin
          emit = 1'b1;
          if (cmd_i.data == '0) begin
            emit_item = fault_item();
            state_d   = ST_IDLE;
          end else if (cmd_i.data[7]) begin
            emit_item = mk_out(ptw_pkg::KIND_DONE, '0, '0,
                               (cmd_i.data[PaW-1:0] & PhysMask & Frame2m) |
                               {31'b0, va_q[20:0]}, ptw_pkg::PAGE_2M);
            state_d   = ST_IDLE;
          end else begin
            emit_item = read_item(cmd_i.data, va_q[20:12]);
            state_d   = ST_L1;
          end
        end
      end
      ST_L1: begin
        if (cmd_pop_o && is_data) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (cmd_i.data == '0) begin
            emit_item = fault_item();
          end else begin
            emit_item = mk_out(ptw_pkg::KIND_DONE, '0, '0,
                               (cmd_i.data[PaW-1:0] & PhysMask & Frame4k) |
                               {40'b0, va_q[11:0]}, ptw_pkg::PAGE_4K);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      va_q          <= '0;
      root_q        <= '0;
      fill_cnt_q    <= '0;
      cache_valid_q <= 1'b0;
      byp_q         <= '0;
      use_byp_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      va_q          <= va_d;
      root_q        <= root_d;
      fill_cnt_q    <= fill_cnt_d;
      cache_valid_q <= cache_valid_d;
      byp_q         <= byp_d;
      use_byp_q     <= use_byp_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_item;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sv/page_table_walker_core.sv
// Four-level page table walker with a 512-entry top-level table cache.
// A read-data beat passes the input queue and then the result register; a translate also goes
// through the LOOKUP state and its registered cache read. Throughput: one beat per cycle into the
// two-entry queue while it is not full; refill words retire one per cycle, and a translate holds
// the walker in LOOKUP for the registered cache read. Reset clears all control state at once;
// the cache reads as zero until its first refill completes, so no clearing pass is run.
module page_table_walker_core #(
  parameter int unsigned PHYS_BITS = 52
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptw_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  ptw_pkg::cmd_t cmd;

  // Input queue and classification.
  ptw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Walker, cache and result register.
  ptw_back #(
    .PHYS_BITS (PHYS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
